FILE: hw/rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and codes of the call stack function profiler.
// ----------------------------------------------------------------------------
package csp_pkg;

  // item commands
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TRACE = 2'd1;
  localparam logic [1:0] CMD_MEM   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // statistic selects
  localparam logic [2:0] STAT_ADDR = 3'd0;

  // counter slots in one counter memory word (select minus one)
  localparam int SLOT_READS    = 0;
  localparam int SLOT_BREAD    = 1;
  localparam int SLOT_WRITES   = 2;
  localparam int SLOT_BWRITTEN = 3;
  localparam int SLOT_CHILD    = 4;
  localparam int SLOT_PUSH     = 5;
  localparam int SLOT_UNIQUE   = 6;
  localparam int NUM_SLOTS     = 7;

  // return address step after a non-call instruction
  localparam logic [31:0] RETURN_STEP = 32'd4;

  typedef enum logic [3:0] {
    OUT_SAVED      = 4'd0,
    OUT_POPPED     = 4'd1,
    OUT_PUSHED     = 4'd2,
    OUT_STACK_FULL = 4'd3,
    OUT_ADDED      = 4'd4,
    OUT_TABLE_FULL = 4'd5,
    OUT_COUNTED    = 4'd6,
    OUT_IGNORED    = 4'd7,
    OUT_STAT       = 4'd8,
    OUT_BAD_INDEX  = 4'd9
  } outcome_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ADD,
    OP_STK_RD,
    OP_POP,
    OP_SAVE_RET,
    OP_RD,
    OP_PTR_INC,
    OP_MEM_WR,
    OP_CALLER_WR,
    OP_CALLEE_WR,
    OP_FULL,
    OP_STAT,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    SEL_TOP,
    SEL_PTR,
    SEL_QRY
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] addr;
    logic        is_write;
    logic [6:0]  nbytes;
    logic [5:0]  entry_index;
    logic [2:0]  stat_select;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  outcome;
    logic [5:0]  matched_index;
    logic [5:0]  depth;
    logic [5:0]  max_depth;
    logic [6:0]  table_count;
    logic [31:0] stat_value;
  } out_word_t;

  typedef struct packed {
    dp_op_e   op;
    rd_sel_e  sel;
    outcome_e outcome;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       depth_zero;
    logic       stack_full;
    logic       table_full;
    logic       top_match;
    logic       addr_match;
    logic       ptr_end;
    logic       qry_ok;
    logic       out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/csp_if.sv
// ----------------------------------------------------------------------------
// csp_in_if / csp_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface csp_in_if
  import csp_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csp_out_if
  import csp_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl
// Sequencer: steps each word through decode and, by command, the stack, table
// search, counter read-modify-write or a query read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module csp_ctrl
  import csp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TOP,
    S_SRCH,
    S_CMP,
    S_CALLER_WR,
    S_CALLEE_RD,
    S_CALLEE_WR,
    S_MEM_TOP,
    S_MEM_WR,
    S_QRY_DATA,
    S_OUT
  } state_e;

  state_e   state_q, state_d;
  outcome_e outcome_q, outcome_d;
  dp_op_e   op;
  rd_sel_e  sel;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = '{op: op, sel: sel, outcome: outcome_q};

  // next state and datapath command
  always_comb begin
    state_d   = state_q;
    outcome_d = outcome_q;
    op        = OP_NONE;
    sel       = SEL_PTR;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LATCH;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.cmd)
          CMD_ADD: begin
            if (status_i.table_full) begin
              outcome_d = OUT_TABLE_FULL;
            end else begin
              op        = OP_ADD;
              outcome_d = OUT_ADDED;
            end
            state_d = S_OUT;
          end
          CMD_TRACE: begin
            if (status_i.depth_zero) begin
              state_d = S_SRCH;
            end else begin
              op      = OP_STK_RD;
              state_d = S_TOP;
            end
          end
          CMD_MEM: begin
            if (status_i.depth_zero) begin
              outcome_d = OUT_IGNORED;
              state_d   = S_OUT;
            end else begin
              op      = OP_STK_RD;
              state_d = S_MEM_TOP;
            end
          end
          default: begin
            if (status_i.qry_ok) begin
              op      = OP_RD;
              sel     = SEL_QRY;
              state_d = S_QRY_DATA;
            end else begin
              outcome_d = OUT_BAD_INDEX;
              state_d   = S_OUT;
            end
          end
        endcase
      end
      S_TOP: begin
        if (status_i.top_match) begin
          op        = OP_POP;
          outcome_d = OUT_POPPED;
          state_d   = S_OUT;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (status_i.ptr_end) begin
          op        = OP_SAVE_RET;
          outcome_d = OUT_SAVED;
          state_d   = S_OUT;
        end else begin
          op      = OP_RD;
          sel     = SEL_PTR;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (!status_i.addr_match) begin
          op      = OP_PTR_INC;
          state_d = S_SRCH;
        end else if (status_i.stack_full) begin
          op        = OP_FULL;
          outcome_d = OUT_STACK_FULL;
          state_d   = S_OUT;
        end else if (status_i.depth_zero) begin
          state_d = S_CALLEE_RD;
        end else begin
          op      = OP_RD;
          sel     = SEL_TOP;
          state_d = S_CALLER_WR;
        end
      end
      S_CALLER_WR: begin
        op      = OP_CALLER_WR;
        state_d = S_CALLEE_RD;
      end
      S_CALLEE_RD: begin
        op      = OP_RD;
        sel     = SEL_PTR;
        state_d = S_CALLEE_WR;
      end
      S_CALLEE_WR: begin
        op        = OP_CALLEE_WR;
        outcome_d = OUT_PUSHED;
        state_d   = S_OUT;
      end
      S_MEM_TOP: begin
        op      = OP_RD;
        sel     = SEL_TOP;
        state_d = S_MEM_WR;
      end
      S_MEM_WR: begin
        op        = OP_MEM_WR;
        outcome_d = OUT_COUNTED;
        state_d   = S_OUT;
      end
      S_QRY_DATA: begin
        op        = OP_STAT;
        outcome_d = OUT_STAT;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          op      = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and outcome registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      outcome_q <= OUT_IGNORED;
    end else begin
      state_q   <= state_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

FILE: hw/rtl/csp_dpath.sv
// ----------------------------------------------------------------------------
// csp_dpath
// Entry table, counter and child bitmap memories, return stack and the
// output register, driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module csp_dpath
  import csp_pkg::*;
#(
  parameter int TABLE_DEPTH   = 64,
  parameter int STACK_DEPTH   = 32,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o
);

  localparam int CW   = COUNTER_WIDTH;
  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int SIW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int QW   = (CNTW > 6) ? CNTW : 6;
  localparam int VW   = (CW > 32) ? CW : 32;
  localparam int WW   = NUM_SLOTS * CW;

  // memories
  logic [31:0]          addr_mem [TABLE_DEPTH];
  logic [WW-1:0]        cnt_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] bmap_mem [TABLE_DEPTH];
  logic [31+IW:0]       stk_mem  [STACK_DEPTH];

  // control registers
  logic [CNTW-1:0] count_q;
  logic [DW-1:0]   depth_q, max_q;
  logic [31:0]     pending_q;
  logic [CNTW-1:0] ptr_q;
  logic            out_valid_q;

  // payload registers
  in_word_t         item_q;
  logic [31:0]      top_ret_q;
  logic [IW-1:0]    top_idx_q;
  logic [31:0]      addr_rdata_q;
  logic [WW-1:0]    cnt_rdata_q;
  logic [TABLE_DEPTH-1:0] bmap_rdata_q;
  logic [IW-1:0]    res_idx_q;
  logic [31:0]      res_stat_q;
  out_word_t        out_q;

  logic [IW-1:0]    ptr_idx, cnt_idx, rd_idx;
  logic [DW-1:0]    top_ptr, depth_inc;
  logic             cnt_we, bmap_we;
  logic [IW-1:0]    cnt_waddr;
  logic [WW-1:0]    cnt_wdata;
  logic [TABLE_DEPTH-1:0] bmap_wdata;
  logic [CW-1:0]    sel_cnt;
  logic [VW-1:0]    sel_ext;
  logic [31:0]      stat_val;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [6:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + (CW + 1)'(b);
    return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  endfunction

  assign ptr_idx   = ptr_q[IW-1:0];
  assign cnt_idx   = count_q[IW-1:0];
  assign top_ptr   = depth_q - DW'(1);
  assign depth_inc = depth_q + DW'(1);

  // read address selection
  always_comb begin
    case (cmd_i.sel)
      SEL_TOP: rd_idx = top_idx_q;
      SEL_QRY: rd_idx = IW'(item_q.entry_index);
      default: rd_idx = ptr_idx;
    endcase
  end

  // counter and bitmap update
  always_comb begin
    cnt_we     = 1'b0;
    bmap_we    = 1'b0;
    cnt_waddr  = top_idx_q;
    cnt_wdata  = cnt_rdata_q;
    bmap_wdata = bmap_rdata_q;
    case (cmd_i.op)
      OP_ADD: begin
        cnt_we     = 1'b1;
        bmap_we    = 1'b1;
        cnt_waddr  = cnt_idx;
        cnt_wdata  = '0;
        bmap_wdata = '0;
      end
      OP_MEM_WR: begin
        cnt_we = 1'b1;
        if (item_q.is_write) begin
          cnt_wdata[SLOT_WRITES*CW +: CW] =
            sat_add(cnt_rdata_q[SLOT_WRITES*CW +: CW], 7'd1);
          cnt_wdata[SLOT_BWRITTEN*CW +: CW] =
            sat_add(cnt_rdata_q[SLOT_BWRITTEN*CW +: CW], item_q.nbytes);
        end else begin
          cnt_wdata[SLOT_READS*CW +: CW] =
            sat_add(cnt_rdata_q[SLOT_READS*CW +: CW], 7'd1);
          cnt_wdata[SLOT_BREAD*CW +: CW] =
            sat_add(cnt_rdata_q[SLOT_BREAD*CW +: CW], item_q.nbytes);
        end
      end
      OP_CALLER_WR: begin
        cnt_we  = 1'b1;
        bmap_we = 1'b1;
        cnt_wdata[SLOT_CHILD*CW +: CW] =
          sat_add(cnt_rdata_q[SLOT_CHILD*CW +: CW], 7'd1);
        if (!bmap_rdata_q[ptr_idx]) begin
          cnt_wdata[SLOT_UNIQUE*CW +: CW] =
            sat_add(cnt_rdata_q[SLOT_UNIQUE*CW +: CW], 7'd1);
        end
        bmap_wdata[ptr_idx] = 1'b1;
      end
      OP_CALLEE_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = ptr_idx;
        cnt_wdata[SLOT_PUSH*CW +: CW] =
          sat_add(cnt_rdata_q[SLOT_PUSH*CW +: CW], 7'd1);
      end
      default: ;
    endcase
  end

  // statistic selection, clipped to 32 bits
  always_comb begin
    sel_cnt = cnt_rdata_q[(int'(item_q.stat_select) - 1) * CW +: CW];
    sel_ext = VW'(sel_cnt);
    if (item_q.stat_select == STAT_ADDR) begin
      stat_val = addr_rdata_q;
    end else if (sel_ext > VW'(32'hFFFF_FFFF)) begin
      stat_val = 32'hFFFF_FFFF;
    end else begin
      stat_val = sel_ext[31:0];
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ADD) begin
      addr_mem[cnt_idx] <= item_q.addr;
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (bmap_we) begin
      bmap_mem[cnt_waddr] <= bmap_wdata;
    end
    if (cmd_i.op == OP_CALLEE_WR) begin
      stk_mem[depth_q[SIW-1:0]] <= {pending_q, ptr_idx};
    end
    if (cmd_i.op == OP_RD) begin
      addr_rdata_q <= addr_mem[rd_idx];
      cnt_rdata_q  <= cnt_mem[rd_idx];
      bmap_rdata_q <= bmap_mem[rd_idx];
    end
    if (cmd_i.op == OP_STK_RD) begin
      {top_ret_q, top_idx_q} <= stk_mem[top_ptr[SIW-1:0]];
    end
  end

  // item, result and output payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        item_q     <= in_data_i;
        res_idx_q  <= '0;
        res_stat_q <= '0;
      end
      OP_ADD:       res_idx_q <= cnt_idx;
      OP_POP:       res_idx_q <= top_idx_q;
      OP_MEM_WR:    res_idx_q <= top_idx_q;
      OP_CALLEE_WR: res_idx_q <= ptr_idx;
      OP_FULL:      res_idx_q <= ptr_idx;
      OP_STAT: begin
        res_idx_q  <= IW'(item_q.entry_index);
        res_stat_q <= stat_val;
      end
      OP_EMIT: begin
        out_q.outcome       <= cmd_i.outcome;
        out_q.matched_index <= 6'(res_idx_q);
        out_q.depth         <= 6'(depth_q);
        out_q.max_depth     <= 6'(max_q);
        out_q.table_count   <= 7'(count_q);
        out_q.stat_value    <= res_stat_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      depth_q     <= '0;
      max_q       <= '0;
      pending_q   <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result takes priority over the word leaving
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LATCH:    ptr_q     <= '0;
        OP_PTR_INC:  ptr_q     <= ptr_q + CNTW'(1);
        OP_ADD:      count_q   <= count_q + CNTW'(1);
        OP_POP:      depth_q   <= top_ptr;
        OP_SAVE_RET: pending_q <= item_q.addr + RETURN_STEP;
        OP_CALLEE_WR: begin
          depth_q <= depth_inc;
          if (depth_inc > max_q) begin
            max_q <= depth_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o = '{
    cmd:        item_q.cmd,
    depth_zero: (depth_q == '0),
    stack_full: (depth_q == DW'(STACK_DEPTH)),
    table_full: (count_q == CNTW'(TABLE_DEPTH)),
    top_match:  (top_ret_q == item_q.addr),
    addr_match: (addr_rdata_q == item_q.addr),
    ptr_end:    (ptr_q >= count_q),
    qry_ok:     (QW'(item_q.entry_index) < QW'(count_q)),
    out_busy:   (out_valid_q && !out_ready_i)
  };

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // consistency checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");
  a_max_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q >= depth_q)
    else $error("deepest seen below current depth");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_CALLEE_WR) |-> (depth_q < DW'(STACK_DEPTH)))
    else $error("push on a full stack");
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ADD) |=> (count_q <= CNTW'(TABLE_DEPTH)) && (count_q != '0))
    else $error("table count out of range after add");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

FILE: hw/rtl/call_stack_function_profiler.sv
// ----------------------------------------------------------------------------
// call_stack_function_profiler
// Function-level profiler: return stack, entry table and per-entry counters.
// ----------------------------------------------------------------------------
// Steps: an add is decided at decode; a pop reads and compares the stack top;
// a memory access reads the stack top entry's counters and writes them back;
// a query reads the entry. A trace search checks loaded entries in turn (one
// table memory read and compare each); a push under a caller does the most.
// Throughput: one word at a time; the next is taken once the result is in
// the output register. Reset clears depth, counts and pending return at once;
// counters and child bitmaps are cleared when their entry is added.
// ----------------------------------------------------------------------------
module call_stack_function_profiler
  import csp_pkg::*;
#(
  parameter int TABLE_DEPTH   = 64,
  parameter int STACK_DEPTH   = 32,
  parameter int COUNTER_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csp_in_if.sink    in_i,
  csp_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  csp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  csp_dpath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .STACK_DEPTH   (STACK_DEPTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule
